// File: rtl/direct_mapped_cache_tag_timing_unit_macros.svh
// Assertion macros for the cache tag timing unit.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef DIRECT_MAPPED_CACHE_TAG_TIMING_UNIT_MACROS_SVH
`define DIRECT_MAPPED_CACHE_TAG_TIMING_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMCT_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmct check failed");

// Consequent must hold in the cycle after the antecedent.
`define DMCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmct check failed");

`endif

// File: rtl/dmct_pkg.sv
package dmct_pkg;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_BITS    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCESS_CYCLES  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_THROUGH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_ALLOCATE = 3'd4;

  // Register field widths and reset values
  localparam int unsigned FIELD_BITS_W = 4;
  localparam int unsigned CYCLES_W     = 10;

  localparam logic [FIELD_BITS_W-1:0] OFFSET_BITS_RST   = 4'd2;
  localparam logic [FIELD_BITS_W-1:0] INDEX_BITS_RST    = 4'd4;
  localparam logic [CYCLES_W-1:0]     ACCESS_CYCLES_RST = 10'd1;

  // Result widths
  localparam int unsigned COST_W = 12;
  localparam int unsigned CNT_W  = 32;

  // Cycles charged for one memory transfer
  localparam logic [COST_W-1:0] MEM_TRANSFER = 12'd120;

  typedef struct packed {
    logic [FIELD_BITS_W-1:0] offset_bits;
    logic [FIELD_BITS_W-1:0] index_bits;
    logic [CYCLES_W-1:0]     access_cycles;
    logic                    write_through;
    logic                    write_allocate;
  } dmct_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;
    logic load_req;
    logic read_en;
    logic commit;
  } dmct_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } dmct_sts_t;

endpackage

// File: rtl/dmct_ram.sv
module dmct_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dmct_ctrl.sv
module dmct_ctrl
  import dmct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dmct_sts_t sts_i,
  output dmct_cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Drive datapath commands
  always_comb begin
    cmd_o.clear_en = (state_q == ST_CLEAR);
    cmd_o.load_req = accept;
    cmd_o.read_en  = (state_q == ST_READ);
    cmd_o.commit   = (state_q == ST_CHECK) && out_free;
  end

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Hold the result until the downstream transaction completes
  assign out_valid_d = cmd_o.commit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/dmct_datapath.sv
module dmct_datapath
  import dmct_pkg::*;
#(
  parameter int unsigned MAX_INDEX_BITS = 10,
  parameter int unsigned ADDRESS_BITS   = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    req_type_i,
  input  logic [ADDRESS_BITS-1:0] address_i,
  input  dmct_cmd_t               cmd_i,
  output dmct_sts_t               sts_o,
  output logic                    hit_o,
  output logic                    wrote_back_o,
  output logic [COST_W-1:0]       access_cost_o,
  output logic [CNT_W-1:0]        total_cycles_o,
  output logic [CNT_W-1:0]        access_count_o,
  output logic [CNT_W-1:0]        hit_count_o,
  output logic [CNT_W-1:0]        miss_count_o
);

  localparam int unsigned IdxW   = MAX_INDEX_BITS;
  localparam int unsigned Depth  = 1 << MAX_INDEX_BITS;
  localparam int unsigned WordW  = ADDRESS_BITS + 2;
  localparam int unsigned ExtW   = ADDRESS_BITS + MAX_INDEX_BITS;
  localparam int unsigned ShW    = FIELD_BITS_W + 1;
  localparam int unsigned LimW   = ShW + 2;

  dmct_cfg_t cfg_q;

  logic                    req_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [IdxW-1:0]         line_q, line_d;
  logic [ADDRESS_BITS-1:0] tag_q, tag_d;
  logic [IdxW-1:0]         clr_q;

  logic [FIELD_BITS_W-1:0] ib_eff;
  logic [FIELD_BITS_W-1:0] ob_eff;
  logic [ShW-1:0]          field_sum;
  logic [ShW-1:0]          tag_shift;
  logic [LimW-1:0]         addr_lim;
  logic [ExtW-1:0]         addr_ext;
  logic [ExtW-1:0]         line_ext;

  logic                    ram_we;
  logic [IdxW-1:0]         ram_waddr;
  logic [WordW-1:0]        ram_wdata;
  logic [WordW-1:0]        ram_rdata;

  logic                    rd_valid, rd_dirty;
  logic [ADDRESS_BITS-1:0] rd_tag;
  logic                    hit;
  logic                    wb;
  logic                    new_valid, new_dirty;
  logic [ADDRESS_BITS-1:0] new_tag;
  logic [COST_W-1:0]       cost;
  logic [COST_W-1:0]       c1, c2, base;

  logic                    hit_q, wb_q;
  logic [COST_W-1:0]       cost_q;
  logic [CNT_W-1:0]        total_q, total_d;
  logic [CNT_W-1:0]        acc_q, hits_q, misses_q;
  logic [CNT_W:0]          total_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_bits    <= OFFSET_BITS_RST;
      cfg_q.index_bits     <= INDEX_BITS_RST;
      cfg_q.access_cycles  <= ACCESS_CYCLES_RST;
      cfg_q.write_through  <= 1'b0;
      cfg_q.write_allocate <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_OFFSET_BITS:    cfg_q.offset_bits    <= cfg_wdata_i[FIELD_BITS_W-1:0];
        CFG_INDEX_BITS:     cfg_q.index_bits     <= cfg_wdata_i[FIELD_BITS_W-1:0];
        CFG_ACCESS_CYCLES:  cfg_q.access_cycles  <= cfg_wdata_i[CYCLES_W-1:0];
        CFG_WRITE_THROUGH:  cfg_q.write_through  <= cfg_wdata_i[0];
        CFG_WRITE_ALLOCATE: cfg_q.write_allocate <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_type_i;
      addr_q <= address_i;
    end
  end

  // Split the address into line index and tag
  always_comb begin
    if ({1'b0, cfg_q.index_bits} > ShW'(MAX_INDEX_BITS)) begin
      ib_eff = FIELD_BITS_W'(MAX_INDEX_BITS);
    end else begin
      ib_eff = cfg_q.index_bits;
    end
    field_sum = ShW'(cfg_q.offset_bits) + ShW'(ib_eff);
    addr_lim  = LimW'(ADDRESS_BITS) - LimW'(ib_eff);
    priority if ({2'b00, field_sum} <= LimW'(ADDRESS_BITS)) begin
      ob_eff = cfg_q.offset_bits;
    end else if (LimW'(ib_eff) >= LimW'(ADDRESS_BITS)) begin
      ob_eff = '0;
    end else begin
      ob_eff = addr_lim[FIELD_BITS_W-1:0];
    end
    tag_shift = ShW'(ob_eff) + ShW'(ib_eff);
    addr_ext  = ExtW'(addr_q);
    line_ext  = (addr_ext >> ob_eff) & ~({ExtW{1'b1}} << ib_eff);
    line_d    = line_ext[IdxW-1:0];
    tag_d     = addr_q >> tag_shift;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      line_q <= line_d;
      tag_q  <= tag_d;
    end
  end

  // Sweep the tag store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_q == {IdxW{1'b1}});

  // Tag store: {valid, dirty, tag} per line
  assign ram_we    = cmd_i.clear_en || cmd_i.commit;
  assign ram_waddr = cmd_i.clear_en ? clr_q : line_q;
  assign ram_wdata = cmd_i.clear_en ? '0 : {new_valid, new_dirty, new_tag};

  dmct_ram #(
    .WIDTH(WordW),
    .DEPTH(Depth)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.read_en),
    .raddr_i(line_d),
    .rdata_o(ram_rdata)
  );

  assign rd_valid = ram_rdata[WordW-1];
  assign rd_dirty = ram_rdata[WordW-2];
  assign rd_tag   = ram_rdata[ADDRESS_BITS-1:0];

  // Apply the write policy and work out the cost
  always_comb begin
    c1        = COST_W'(cfg_q.access_cycles);
    c2        = {c1[COST_W-2:0], 1'b0};
    hit       = rd_valid && (rd_tag == tag_q);
    wb        = 1'b0;
    new_valid = rd_valid;
    new_dirty = rd_dirty;
    new_tag   = rd_tag;
    base      = '0;
    cost      = '0;
    if (hit) begin
      if (req_q && cfg_q.write_through) begin
        cost = c1 + MEM_TRANSFER;
      end else begin
        cost = c1;
        if (req_q) begin
          new_dirty = 1'b1;
        end
      end
    end else begin
      wb        = rd_dirty;
      new_dirty = 1'b0;
      base      = rd_dirty ? MEM_TRANSFER : '0;
      priority if (!req_q) begin
        new_valid = 1'b1;
        new_tag   = tag_q;
        cost      = base + c1 + MEM_TRANSFER;
      end else if (cfg_q.write_allocate) begin
        new_valid = 1'b1;
        new_tag   = tag_q;
        if (cfg_q.write_through) begin
          cost = base + c2 + MEM_TRANSFER + MEM_TRANSFER;
        end else begin
          cost      = base + c2 + MEM_TRANSFER;
          new_dirty = 1'b1;
        end
      end else begin
        cost = base + c1 + MEM_TRANSFER;
      end
    end
  end

  // Saturating cycle total
  assign total_sum = {1'b0, total_q} + (CNT_W + 1)'(cost);
  assign total_d   = total_sum[CNT_W] ? {CNT_W{1'b1}} : total_sum[CNT_W-1:0];

  // Update the statistics counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      acc_q    <= '0;
      hits_q   <= '0;
      misses_q <= '0;
    end else if (cmd_i.commit) begin
      total_q <= total_d;
      if (acc_q != {CNT_W{1'b1}}) begin
        acc_q <= acc_q + 1'b1;
      end
      if (hit && (hits_q != {CNT_W{1'b1}})) begin
        hits_q <= hits_q + 1'b1;
      end
      if (!hit && (misses_q != {CNT_W{1'b1}})) begin
        misses_q <= misses_q + 1'b1;
      end
    end
  end

  // Per-access result
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q  <= hit;
      wb_q   <= wb;
      cost_q <= cost;
    end
  end

  assign hit_o          = hit_q;
  assign wrote_back_o   = wb_q;
  assign access_cost_o  = cost_q;
  assign total_cycles_o = total_q;
  assign access_count_o = acc_q;
  assign hit_count_o    = hits_q;
  assign miss_count_o   = misses_q;

endmodule

// File: rtl/direct_mapped_cache_tag_timing_unit.sv
// Direct-mapped cache tag and timing unit. Each access (read or write to a
// byte address) is looked up in a tag store with valid and dirty bits, the
// write policy is applied, and one result comes back with hit, write-back,
// the cycles charged and the saturating running totals. After reset the
// tag store is swept clear line by line with in_stall_o high;
// configuration writes are taken during the sweep. For each access the
// transaction is taken, the tag RAM is read at the line index, and the
// line is compared and written back once the output register is free;
// that read-then-write of the single tag RAM means a new access is taken
// only after the last one is written back. A finished result waits in
// the output register while the next access is taken and looked up.
module direct_mapped_cache_tag_timing_unit
  import dmct_pkg::*;
#(
  parameter int unsigned MAX_INDEX_BITS = 10,
  parameter int unsigned ADDRESS_BITS   = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    req_type_i,
  input  logic [ADDRESS_BITS-1:0] address_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic                    wrote_back_o,
  output logic [COST_W-1:0]       access_cost_o,
  output logic [CNT_W-1:0]        total_cycles_o,
  output logic [CNT_W-1:0]        access_count_o,
  output logic [CNT_W-1:0]        hit_count_o,
  output logic [CNT_W-1:0]        miss_count_o
);

  dmct_cmd_t cmd;
  dmct_sts_t sts;

  dmct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dmct_datapath #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS),
    .ADDRESS_BITS  (ADDRESS_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (req_type_i),
    .address_i     (address_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hit_o         (hit_o),
    .wrote_back_o  (wrote_back_o),
    .access_cost_o (access_cost_o),
    .total_cycles_o(total_cycles_o),
    .access_count_o(access_count_o),
    .hit_count_o   (hit_count_o),
    .miss_count_o  (miss_count_o)
  );

endmodule

// File: rtl/dmct_checker.sv
`include "direct_mapped_cache_tag_timing_unit_macros.svh"

module dmct_checker
  import dmct_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              hit_o,
  input logic              wrote_back_o,
  input logic [COST_W-1:0] access_cost_o,
  input logic [CNT_W-1:0]  access_count_o
);

  // A stalled result holds its payload
  `DMCT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(access_cost_o) && $stable(access_count_o))

  // One access in flight: a taken transaction closes the input
  `DMCT_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o)

  // A hit never evicts a line
  `DMCT_ASSERT_SAME(a_hit_no_wb, out_valid_o && hit_o, !wrote_back_o)

  // Every miss pays at least one memory transfer
  `DMCT_ASSERT_SAME(a_miss_cost, out_valid_o && !hit_o, access_cost_o >= MEM_TRANSFER)

endmodule

bind direct_mapped_cache_tag_timing_unit dmct_checker u_dmct_checker (.*);
